@@ src/dhof_pkg.sv @@
// Package with the sizes, register map, codes and state type of the depth histogram filter.
`timescale 1ns / 1ps

package dhof_pkg;

    // Batch capacity and histogram size.
    localparam int MAX_POINTS = 64;
    localparam int BINS       = 50;

    // Derived widths.
    localparam int PT_W   = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int BIN_W  = $clog2(BINS);
    localparam int STEP_W = $clog2(BIN_W + 1);
    localparam int DIV_W  = 23 + BIN_W + 1;
    localparam int ADDR_W = 5;

    // Register indexes within the configuration map.
    localparam logic [2:0] REG_LOWEST_DEPTH = 3'd0;
    localparam logic [2:0] REG_BIN_WIDTH    = 3'd1;
    localparam logic [2:0] REG_WINDOW_LOW   = 3'd2;
    localparam logic [2:0] REG_WINDOW_HIGH  = 3'd3;
    localparam logic [2:0] REG_SCALE_SQ     = 3'd4;

    // Register values after reset.
    localparam logic [23:0] RST_LOWEST_DEPTH = 24'hCE0000;
    localparam logic [22:0] RST_BIN_WIDTH    = 23'd64225;
    localparam logic [23:0] RST_WINDOW_LOW   = 24'hE20000;
    localparam logic [23:0] RST_WINDOW_HIGH  = 24'd0;
    localparam logic [15:0] RST_SCALE_SQ     = 16'd29420;

    // Verdict codes.
    localparam logic [1:0] CAUSE_KEPT    = 2'd0;
    localparam logic [1:0] CAUSE_FRONT   = 2'd1;
    localparam logic [1:0] CAUSE_DEEP    = 2'd2;
    localparam logic [1:0] CAUSE_DENSITY = 2'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_CLEAR,
        S_LOAD,
        S_H_READ,
        S_H_CHECK,
        S_H_DIV,
        S_H_BRD,
        S_H_INC,
        S_M_SCAN,
        S_M_MODE,
        S_W_READ,
        S_W_DIFF,
        S_W_SQ,
        S_W_ACC,
        S_R_LO,
        S_R_HI,
        S_V_READ,
        S_V_DIFF,
        S_V_SQ,
        S_V_MUL,
        S_V_CMP,
        S_V_OUT
    } t_state;

endpackage

@@ src/dhof_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module dhof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data registered; a read of the entry written in the same cycle returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/depth_histogram_outlier_filter.sv @@
// Top level of the depth histogram outlier filter: config port, sequencer and datapath.
`timescale 1ns / 1ps

// Loads a batch of Q8.16 depths, one beat per cycle, until a beat marks the last point or
// MAX_POINTS points are held, then judges the batch and sends one verdict beat per point in
// load order. Judging runs as passes over the depth memory, one point at a time: a histogram
// pass in which the restoring divider takes one quotient bit a cycle, a mode scan that also
// clears the bin memory, a variance pass, a scale product formed in low and high halves, and
// a verdict pass that an output stall can hold. The input is stalled from the last beat of a
// batch until its final verdict leaves. After reset a clearing pass runs over the bin memory
// before the first beat is taken. The user must write configuration only while idle; the
// block itself does not enforce it.
module depth_histogram_outlier_filter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Point input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [23:0]        i_point_depth,
    input  logic                      i_last_point,
    // Verdict output channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [5:0]                o_point_index,
    output logic                      o_rejected,
    output logic [1:0]                o_reject_cause,
    output logic                      o_last_result,
    // Configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [dhof_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int PT_W  = dhof_pkg::PT_W;
    localparam int CNT_W = dhof_pkg::CNT_W;
    localparam int BIN_W = dhof_pkg::BIN_W;
    localparam int STEP_W = dhof_pkg::STEP_W;
    localparam int DIV_W = dhof_pkg::DIV_W;

    // Configuration registers
    logic signed [23:0] r_lowest;
    logic [22:0]        r_bin_width;
    logic signed [23:0] r_win_low;
    logic signed [23:0] r_win_high;
    logic [15:0]        r_scale;

    // Sequencer and datapath state
    dhof_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [PT_W-1:0]    r_pt;
    logic [BIN_W:0]     r_idx;
    logic [CNT_W-1:0]   r_best;
    logic [BIN_W-1:0]   r_best_idx;
    logic signed [23:0] r_x;
    logic [DIV_W-1:0]   r_rem;
    logic [STEP_W-1:0]  r_step;
    logic [BIN_W-1:0]   r_q;
    logic signed [31:0] r_mode;
    logic [30:0]        r_d;
    logic [61:0]        r_d2;
    logic [63:0]        r_sum;
    logic [CNT_W-1:0]   r_wcount;
    logic [47:0]        r_rhs_lo;
    logic [79:0]        r_rhs;
    logic [63:0]        r_lhs;
    logic [5:0]         r_out_idx;
    logic [1:0]         r_out_cause;
    logic               r_out_last;

    // Memory ports
    logic               w_dep_we;
    logic [23:0]        w_dep_rdata;
    logic               w_bin_we;
    logic [BIN_W-1:0]   w_bin_waddr;
    logic [CNT_W-1:0]   w_bin_wdata;
    logic [BIN_W-1:0]   w_bin_raddr;
    logic [CNT_W-1:0]   w_bin_rdata;

    // Shared combinational terms
    logic               w_cfg_wr;
    logic               w_in_acc;
    logic               w_pt_last;
    logic               w_load_end;
    logic signed [23:0] w_x;
    logic [DIV_W-1:0]   w_num;
    logic [DIV_W-1:0]   w_span;
    logic               w_h_skip;
    logic [DIV_W-1:0]   w_div_sub;
    logic               w_div_ge;
    logic signed [32:0] w_diff;
    logic [31:0]        w_absdiff;
    logic               w_in_win;
    logic               w_scan_data;
    logic [BIN_W-1:0]   w_scan_prev;
    logic               w_low_density;

    dhof_ram #(.WIDTH(24), .DEPTH(dhof_pkg::MAX_POINTS)) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (w_dep_we),
        .i_waddr (r_count[PT_W-1:0]),
        .i_wdata (i_point_depth),
        .i_raddr (r_pt),
        .o_rdata (w_dep_rdata)
    );

    dhof_ram #(.WIDTH(CNT_W), .DEPTH(dhof_pkg::BINS)) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (w_bin_we),
        .i_waddr (w_bin_waddr),
        .i_wdata (w_bin_wdata),
        .i_raddr (w_bin_raddr),
        .o_rdata (w_bin_rdata)
    );

    // Configuration write and read-back.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest    <= dhof_pkg::RST_LOWEST_DEPTH;
            r_bin_width <= dhof_pkg::RST_BIN_WIDTH;
            r_win_low   <= dhof_pkg::RST_WINDOW_LOW;
            r_win_high  <= dhof_pkg::RST_WINDOW_HIGH;
            r_scale     <= dhof_pkg::RST_SCALE_SQ;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                dhof_pkg::REG_LOWEST_DEPTH: r_lowest    <= pwdata[23:0];
                dhof_pkg::REG_BIN_WIDTH:    r_bin_width <= pwdata[22:0];
                dhof_pkg::REG_WINDOW_LOW:   r_win_low   <= pwdata[23:0];
                dhof_pkg::REG_WINDOW_HIGH:  r_win_high  <= pwdata[23:0];
                dhof_pkg::REG_SCALE_SQ:     r_scale     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            dhof_pkg::REG_LOWEST_DEPTH: prdata = 32'(r_lowest);
            dhof_pkg::REG_BIN_WIDTH:    prdata = {9'd0, r_bin_width};
            dhof_pkg::REG_WINDOW_LOW:   prdata = 32'(r_win_low);
            dhof_pkg::REG_WINDOW_HIGH:  prdata = 32'(r_win_high);
            dhof_pkg::REG_SCALE_SQ:     prdata = {16'd0, r_scale};
            default:                    prdata = 32'd0;
        endcase
    end

    // Shared datapath terms.
    assign w_in_acc   = i_valid && !o_stall;
    assign w_pt_last  = (CNT_W'(r_pt) + CNT_W'(1)) == r_count;
    assign w_load_end = i_last_point ||
                        ((r_count + CNT_W'(1)) == CNT_W'(dhof_pkg::MAX_POINTS));
    assign w_x        = $signed(w_dep_rdata);

    // Offset into the histogram range; only used when the depth lies above the floor.
    assign w_num  = DIV_W'(34'(w_x) - 34'(r_lowest) - 34'sd1);
    assign w_span = DIV_W'(r_bin_width) * DIV_W'(dhof_pkg::BINS);
    assign w_h_skip = (w_x > 24'sd0) || (w_x <= r_lowest) || (r_bin_width == 23'd0) ||
                      (w_num >= w_span);

    // One restoring division step per cycle.
    assign w_div_ge  = r_rem >= (DIV_W'(r_bin_width) << r_step);
    assign w_div_sub = r_rem - (DIV_W'(r_bin_width) << r_step);

    // Distance from the reference depth.
    assign w_diff    = 33'(w_x) - 33'(r_mode);
    assign w_absdiff = w_diff[32] ? 32'(-w_diff) : w_diff[31:0];
    assign w_in_win  = (w_x > r_win_low) && (w_x < r_win_high);

    // Mode scan: the bin read issued last cycle is compared now.
    assign w_scan_data = r_idx != '0;
    assign w_scan_prev = BIN_W'(r_idx - (BIN_W+1)'(1));

    assign w_low_density = (r_wcount != '0) && ({4'd0, r_lhs, 12'd0} > r_rhs);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dhof_pkg::S_CLEAR: begin
                if (r_idx == (BIN_W+1)'(dhof_pkg::BINS - 1)) n_state = dhof_pkg::S_LOAD;
            end
            dhof_pkg::S_LOAD: begin
                if (w_in_acc && w_load_end) n_state = dhof_pkg::S_H_READ;
            end
            dhof_pkg::S_H_READ:  n_state = dhof_pkg::S_H_CHECK;
            dhof_pkg::S_H_CHECK: begin
                if (!w_h_skip)      n_state = dhof_pkg::S_H_DIV;
                else if (w_pt_last) n_state = dhof_pkg::S_M_SCAN;
                else                n_state = dhof_pkg::S_H_READ;
            end
            dhof_pkg::S_H_DIV: begin
                if (r_step == '0) n_state = dhof_pkg::S_H_BRD;
            end
            dhof_pkg::S_H_BRD: n_state = dhof_pkg::S_H_INC;
            dhof_pkg::S_H_INC: begin
                n_state = w_pt_last ? dhof_pkg::S_M_SCAN : dhof_pkg::S_H_READ;
            end
            dhof_pkg::S_M_SCAN: begin
                if (r_idx == (BIN_W+1)'(dhof_pkg::BINS)) n_state = dhof_pkg::S_M_MODE;
            end
            dhof_pkg::S_M_MODE: n_state = dhof_pkg::S_W_READ;
            dhof_pkg::S_W_READ: n_state = dhof_pkg::S_W_DIFF;
            dhof_pkg::S_W_DIFF: begin
                if (w_in_win)       n_state = dhof_pkg::S_W_SQ;
                else if (w_pt_last) n_state = dhof_pkg::S_R_LO;
                else                n_state = dhof_pkg::S_W_READ;
            end
            dhof_pkg::S_W_SQ:  n_state = dhof_pkg::S_W_ACC;
            dhof_pkg::S_W_ACC: n_state = w_pt_last ? dhof_pkg::S_R_LO : dhof_pkg::S_W_READ;
            dhof_pkg::S_R_LO:  n_state = dhof_pkg::S_R_HI;
            dhof_pkg::S_R_HI:  n_state = dhof_pkg::S_V_READ;
            dhof_pkg::S_V_READ: n_state = dhof_pkg::S_V_DIFF;
            dhof_pkg::S_V_DIFF: n_state = dhof_pkg::S_V_SQ;
            dhof_pkg::S_V_SQ:   n_state = dhof_pkg::S_V_MUL;
            dhof_pkg::S_V_MUL:  n_state = dhof_pkg::S_V_CMP;
            dhof_pkg::S_V_CMP:  n_state = dhof_pkg::S_V_OUT;
            dhof_pkg::S_V_OUT: begin
                if (!i_stall) begin
                    n_state = w_pt_last ? dhof_pkg::S_LOAD : dhof_pkg::S_V_READ;
                end
            end
            default: n_state = dhof_pkg::S_CLEAR;
        endcase
    end

    // Handshake and memory controls.
    always_comb begin
        o_stall     = r_state != dhof_pkg::S_LOAD;
        o_valid     = r_state == dhof_pkg::S_V_OUT;
        w_dep_we    = (r_state == dhof_pkg::S_LOAD) && i_valid;
        w_bin_we    = 1'b0;
        w_bin_waddr = r_q;
        w_bin_wdata = w_bin_rdata + CNT_W'(1);
        w_bin_raddr = r_q;
        case (r_state)
            dhof_pkg::S_CLEAR: begin
                w_bin_we    = 1'b1;
                w_bin_waddr = r_idx[BIN_W-1:0];
                w_bin_wdata = '0;
            end
            dhof_pkg::S_H_INC: begin
                w_bin_we = 1'b1;
            end
            dhof_pkg::S_M_SCAN: begin
                w_bin_raddr = r_idx[BIN_W-1:0];
                w_bin_we    = w_scan_data;
                w_bin_waddr = w_scan_prev;
                w_bin_wdata = '0;
            end
            default: ;
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dhof_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pt    <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                dhof_pkg::S_CLEAR: begin
                    r_idx <= (r_idx == (BIN_W+1)'(dhof_pkg::BINS - 1)) ? '0
                                                                       : r_idx + (BIN_W+1)'(1);
                end
                dhof_pkg::S_LOAD: begin
                    r_pt  <= '0;
                    r_idx <= '0;
                    if (w_in_acc) r_count <= r_count + CNT_W'(1);
                end
                dhof_pkg::S_H_CHECK: begin
                    if (w_h_skip && !w_pt_last) r_pt <= r_pt + PT_W'(1);
                end
                dhof_pkg::S_H_INC: begin
                    if (!w_pt_last) r_pt <= r_pt + PT_W'(1);
                end
                dhof_pkg::S_M_SCAN: begin
                    r_idx <= r_idx + (BIN_W+1)'(1);
                    r_pt  <= '0;
                end
                dhof_pkg::S_W_DIFF: begin
                    if (!w_in_win && !w_pt_last) r_pt <= r_pt + PT_W'(1);
                end
                dhof_pkg::S_W_ACC: begin
                    if (!w_pt_last) r_pt <= r_pt + PT_W'(1);
                end
                dhof_pkg::S_R_HI: begin
                    r_pt <= '0;
                end
                dhof_pkg::S_V_OUT: begin
                    if (!i_stall) begin
                        if (w_pt_last) r_count <= '0;
                        else           r_pt    <= r_pt + PT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            dhof_pkg::S_LOAD: begin
                r_best     <= '0;
                r_best_idx <= '0;
            end
            dhof_pkg::S_H_CHECK: begin
                r_rem  <= w_num;
                r_step <= STEP_W'(BIN_W - 1);
                r_q    <= '0;
            end
            dhof_pkg::S_H_DIV: begin
                if (w_div_ge) r_rem <= w_div_sub;
                r_q    <= BIN_W'({r_q, w_div_ge});
                r_step <= r_step - STEP_W'(1);
            end
            dhof_pkg::S_M_SCAN: begin
                if (w_scan_data && (w_bin_rdata > r_best)) begin
                    r_best     <= w_bin_rdata;
                    r_best_idx <= w_scan_prev;
                end
            end
            dhof_pkg::S_M_MODE: begin
                r_mode   <= 32'(r_lowest) + 32'(r_best_idx) * 32'(r_bin_width);
                r_sum    <= '0;
                r_wcount <= '0;
            end
            dhof_pkg::S_W_DIFF: begin
                r_d <= w_absdiff[30:0];
            end
            dhof_pkg::S_W_SQ: begin
                r_d2 <= 62'(r_d) * 62'(r_d);
            end
            dhof_pkg::S_W_ACC: begin
                r_sum    <= r_sum + 64'(r_d2);
                r_wcount <= r_wcount + CNT_W'(1);
            end
            dhof_pkg::S_R_LO: begin
                r_rhs_lo <= 48'(r_scale) * 48'(r_sum[31:0]);
            end
            dhof_pkg::S_R_HI: begin
                r_rhs <= 80'(r_rhs_lo) + {48'(r_scale) * 48'(r_sum[63:32]), 32'd0};
            end
            dhof_pkg::S_V_DIFF: begin
                r_x <= w_x;
                r_d <= w_absdiff[30:0];
            end
            dhof_pkg::S_V_SQ: begin
                r_d2 <= 62'(r_d) * 62'(r_d);
            end
            dhof_pkg::S_V_MUL: begin
                r_lhs <= {2'b00, r_d2} * 64'(r_wcount);
            end
            dhof_pkg::S_V_CMP: begin
                // First applicable cause wins.
                if (r_x > 24'sd0)        r_out_cause <= dhof_pkg::CAUSE_FRONT;
                else if (r_x < r_lowest) r_out_cause <= dhof_pkg::CAUSE_DEEP;
                else if (w_low_density)  r_out_cause <= dhof_pkg::CAUSE_DENSITY;
                else                     r_out_cause <= dhof_pkg::CAUSE_KEPT;
                r_out_idx  <= 6'(r_pt);
                r_out_last <= w_pt_last;
            end
            default: ;
        endcase
    end

    assign o_point_index  = r_out_idx;
    assign o_reject_cause = r_out_cause;
    assign o_rejected     = r_out_cause != dhof_pkg::CAUSE_KEPT;
    assign o_last_result  = r_out_last;

endmodule
